### rtl/page_region_admit_allocator_assert.svh
// Assertion macros used by the page region allocator checker.
`ifndef PAGE_REGION_ADMIT_ALLOCATOR_ASSERT_SVH
`define PAGE_REGION_ADMIT_ALLOCATOR_ASSERT_SVH
`define PRA_ASSERT_IMPLIES(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");
`define PRA_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

### rtl/pra_pkg.sv
// Shared types and constants of the page region allocator.
package pra_pkg;
    localparam int AW = 64;
    localparam int FW = 52;
    localparam int PAGE_SHIFT = 12;
    localparam logic [31:0] CONV_TYPE = 32'd7;
    localparam int NRES = 3;
    localparam logic [1:0] FUNC_OFFER = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [2:0] CFG_LIMIT = 3'd6;

    typedef struct packed {
        logic load;
        logic trim;
        logic finish_offer;
        logic store;
        logic set_full;
        logic check;
        logic read;
        logic grant;
        logic advance;
        logic match;
        logic respond;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic admitted;
        logic limit_hit;
        logic slot_valid;
        logic slot_room;
        logic hit;
        logic full;
        logic store_full;
    } status_t;
endpackage

### rtl/page_region_admit_allocator.sv
// Top level of the page region admission and bump page allocator.
//  channel | direction | contents
//  s_      | in        | tuser func; tdata mem_type, phys_start, page_count, query_addr
//  m_      | out       | tuser ok, overflowed; tdata page_addr .. allocated_total
//  cfg_    | in        | register index and 64-bit value
// An offer makes three trim steps against the reserved ranges.
// An allocation reads the region under the cursor and skips each exhausted region.
// A query reads each stored region in turn through the single region RAM read port.
// Reset is synchronous; stores need no clearing. One item is in flight at a time.
module page_region_admit_allocator #(
    parameter int MAX_REGIONS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // func
    input  logic [223:0] s_tdata,   // mem_type, phys_start, page_count, query_addr
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [1:0]   m_tuser,   // ok, overflowed
    output logic [327:0] m_tdata,   // page_addr, admitted_base, admitted_pages,
                                    // region_total, pages_total, allocated_total, pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    pra_pkg::cmd_t cmd;
    pra_pkg::status_t st;
    logic [1:0] tidx;
    logic [CW-1:0] sidx, stored;
    logic r_ok, r_full;
    logic [63:0] r_page, r_base, r_np, r_sum, r_gr;

    assign cfg_ready = 1'b1;

    pra_ctrl #(.MAX_REGIONS(MAX_REGIONS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_func(s_tuser), .out_valid(m_tvalid), .out_ready(m_tready), .st(st),
        .stored(stored), .trim_idx(tidx), .scan_idx(sidx), .cmd(cmd));

    pra_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_valid), .cfg_idx(cfg_index),
        .cfg_val(cfg_data), .in_type(s_tdata[31:0]), .in_start(s_tdata[95:32]),
        .in_pages(s_tdata[159:96]), .in_query(s_tdata[223:160]), .trim_idx(tidx),
        .scan_idx(sidx), .cmd(cmd), .st(st), .stored_o(stored), .r_ok(r_ok),
        .r_page(r_page), .r_base(r_base), .r_npages(r_np), .r_sum(r_sum),
        .r_granted(r_gr), .r_full(r_full));

    assign m_tuser = {r_full, r_ok};
    assign m_tdata = {1'b0, r_gr, r_sum, 7'(stored), r_np, r_base, r_page};
endmodule

### rtl/pra_ram.sv
// Generic single-port write, single-port registered-read RAM.
module pra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/pra_datapath.sv
// Datapath of the page region allocator: trim unit, region store, cursors, counters.
module pra_datapath #(
    parameter int MAX_REGIONS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_idx,
    input  logic [63:0]                cfg_val,
    input  logic [31:0]                in_type,
    input  logic [63:0]                in_start,
    input  logic [63:0]                in_pages,
    input  logic [63:0]                in_query,
    input  logic [1:0]                 trim_idx,
    input  logic [$clog2(MAX_REGIONS+1)-1:0] scan_idx,
    input  pra_pkg::cmd_t              cmd,
    output pra_pkg::status_t           st,
    output logic [$clog2(MAX_REGIONS+1)-1:0] stored_o,
    output logic                       r_ok,
    output logic [63:0]                r_page,
    output logic [63:0]                r_base,
    output logic [63:0]                r_npages,
    output logic [63:0]                r_sum,
    output logic [63:0]                r_granted,
    output logic                       r_full
);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int FW = pra_pkg::FW;

    logic [63:0] rbase_reg [pra_pkg::NRES];
    logic [63:0] rsize_reg [pra_pkg::NRES];
    logic [63:0] limit_reg;
    logic [63:0] lo_reg, hi_reg, lo_next, hi_next;
    logic [63:0] query_reg;
    logic        reject_reg, reject_next;
    logic [CW-1:0] stored_reg, cslot_reg;
    logic [FW-1:0] coff_reg;
    logic [63:0] sum_reg, granted_reg;
    logic        full_reg;
    logic [FW-1:0] frame_rd, len_rd;
    logic [IW-1:0] raddr;
    logic        hit_reg;

    always_ff @(posedge aclk) begin
        if (cfg_we) begin
            if (cfg_idx == pra_pkg::CFG_LIMIT) begin
                limit_reg <= cfg_val;
            end else if (cfg_idx < pra_pkg::CFG_LIMIT) begin
                if (cfg_idx[0]) rsize_reg[cfg_idx[2:1]] <= cfg_val;
                else rbase_reg[cfg_idx[2:1]] <= cfg_val;
            end
        end
        if (!aresetn) begin
            for (int i = 0; i < pra_pkg::NRES; i++) begin
                rbase_reg[i] <= '0;
                rsize_reg[i] <= '0;
            end
            limit_reg <= '0;
        end
    end

    logic [63:0] r0, r1, lo_rnd, hi_rnd;
    logic [64:0] end_sum;
    always_comb begin
        r0 = rbase_reg[trim_idx];
        r1 = rbase_reg[trim_idx] + rsize_reg[trim_idx];
        end_sum = {1'b0, in_start} + {1'b0, in_pages[51:0], 12'd0};
        lo_rnd = (lo_reg + 64'hFFF) & ~64'hFFF;
        hi_rnd = hi_reg & ~64'hFFF;
        lo_next = lo_reg;
        hi_next = hi_reg;
        reject_next = reject_reg;
        if (cmd.load) begin
            lo_next = in_start;
            hi_next = end_sum[63:0];
            reject_next = (in_type != pra_pkg::CONV_TYPE) || (in_pages == 64'd0)
                || (in_start[11:0] != 12'd0) || (in_pages[63:52] != 12'd0)
                || (end_sum[63:0] <= in_start);
        end else if (cmd.trim && !reject_reg) begin
            if (r1 <= lo_reg || r0 >= hi_reg) begin
            end else if (r0 <= lo_reg && r1 >= hi_reg) begin
                reject_next = 1'b1;
            end else if (r0 <= lo_reg) begin
                lo_next = r1;
            end else if (r1 >= hi_reg) begin
                hi_next = r0;
            end else begin
                reject_next = 1'b1;
            end
        end else if (cmd.finish_offer && !reject_reg) begin
            lo_next = lo_rnd;
            hi_next = hi_rnd;
            reject_next = hi_rnd <= lo_rnd;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        reject_reg <= reject_next;
        if (cmd.load) query_reg <= in_query;
    end

    logic [63:0] npages;
    assign npages = (hi_reg - lo_reg) >> pra_pkg::PAGE_SHIFT;

    pra_ram #(.WIDTH(FW), .DEPTH(MAX_REGIONS)) u_frame (
        .aclk(aclk), .we(cmd.store), .waddr(stored_reg[IW-1:0]),
        .wdata(lo_reg[63:12]), .raddr(raddr), .rdata(frame_rd));
    pra_ram #(.WIDTH(FW), .DEPTH(MAX_REGIONS)) u_len (
        .aclk(aclk), .we(cmd.store), .waddr(stored_reg[IW-1:0]),
        .wdata(npages[FW-1:0]), .raddr(raddr), .rdata(len_rd));

    assign raddr = cmd.read ? cslot_reg[IW-1:0] : scan_idx[IW-1:0];

    logic [63:0] b_addr, e_addr;
    assign b_addr = {frame_rd, 12'd0};
    assign e_addr = b_addr + {len_rd, 12'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_reg <= '0;
            cslot_reg <= '0;
            coff_reg <= '0;
            sum_reg <= '0;
            granted_reg <= '0;
            full_reg <= 1'b0;
            hit_reg <= 1'b0;
            r_ok <= 1'b0;
            r_page <= '0;
            r_base <= '0;
            r_npages <= '0;
        end else begin
            if (cmd.load) begin
                hit_reg <= 1'b0;
                r_ok <= 1'b0;
                r_page <= '0;
                r_base <= '0;
                r_npages <= '0;
            end
            if (cmd.store) begin
                stored_reg <= stored_reg + 1'b1;
                sum_reg <= sum_reg + npages;
                r_ok <= 1'b1;
                r_base <= lo_reg;
                r_npages <= npages;
            end
            if (cmd.set_full) full_reg <= 1'b1;
            if (cmd.grant) begin
                r_page <= b_addr + {coff_reg, 12'd0};
                r_ok <= (b_addr + {coff_reg, 12'd0}) != 64'd0;
                coff_reg <= coff_reg + 1'b1;
                granted_reg <= granted_reg + 64'd1;
            end
            if (cmd.advance) begin
                cslot_reg <= cslot_reg + 1'b1;
                coff_reg <= '0;
            end
            if (cmd.match && query_reg >= b_addr && query_reg < e_addr) begin
                hit_reg <= 1'b1;
            end
            if (cmd.respond && hit_reg) r_ok <= 1'b1;
        end
    end

    assign st.reject = reject_reg;
    assign st.admitted = !reject_reg;
    assign st.limit_hit = (limit_reg != 64'd0) && (granted_reg >= limit_reg);
    assign st.slot_valid = (cslot_reg < stored_reg);
    assign st.slot_room = {{(64-FW){1'b0}}, coff_reg} < {{(64-FW){1'b0}}, len_rd};
    assign st.hit = hit_reg;
    assign st.full = full_reg;
    assign st.store_full = (stored_reg >= CW'(MAX_REGIONS));
    assign stored_o = stored_reg;
    assign r_sum = sum_reg;
    assign r_granted = granted_reg;
    assign r_full = full_reg;
    logic unused_cmd;
    assign unused_cmd = cmd.check;
endmodule

### rtl/pra_ctrl.sv
// Controller state machine of the page region allocator.
module pra_ctrl #(
    parameter int MAX_REGIONS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_func,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pra_pkg::status_t     st,
    input  logic [$clog2(MAX_REGIONS+1)-1:0] stored,
    output logic [1:0]           trim_idx,
    output logic [$clog2(MAX_REGIONS+1)-1:0] scan_idx,
    output pra_pkg::cmd_t        cmd
);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    typedef enum logic [3:0] {
        S_IDLE, S_TRIM, S_ROUND, S_STORE, S_ARD, S_AWAIT, S_ACHK,
        S_QRD, S_QWAIT, S_QCMP, S_FIN, S_OUT
    } state_t;
    state_t state_reg;
    logic [1:0] func_reg, tidx_reg;
    logic [CW-1:0] sidx_reg;
    logic out_valid_reg;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign trim_idx = tidx_reg;
    assign scan_idx = sidx_reg;

    always_comb begin
        cmd = '0;
        case (state_reg)
            S_IDLE: cmd.load = in_valid && in_ready;
            S_TRIM: cmd.trim = 1'b1;
            S_ROUND: cmd.finish_offer = 1'b1;
            S_STORE: begin
                cmd.store = !st.reject && !st.full && !st.store_full;
                cmd.set_full = !st.reject && !st.full && st.store_full;
            end
            S_ARD: cmd.read = 1'b1;
            S_AWAIT: cmd.read = 1'b1;
            S_ACHK: begin
                cmd.grant = st.slot_valid && st.slot_room;
                cmd.advance = st.slot_valid && !st.slot_room;
            end
            S_QCMP: cmd.match = 1'b1;
            S_FIN: cmd.respond = 1'b1;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            func_reg <= '0;
            tidx_reg <= '0;
            sidx_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (in_valid && in_ready) begin
                    func_reg <= in_func;
                    tidx_reg <= '0;
                    sidx_reg <= '0;
                    case (in_func)
                        pra_pkg::FUNC_OFFER: state_reg <= S_TRIM;
                        pra_pkg::FUNC_ALLOC: state_reg <= S_ARD;
                        pra_pkg::FUNC_QUERY: state_reg <= S_QRD;
                        default: state_reg <= S_FIN;
                    endcase
                end
                S_TRIM: begin
                    tidx_reg <= tidx_reg + 2'd1;
                    if (tidx_reg == 2'd2) state_reg <= S_ROUND;
                end
                S_ROUND: state_reg <= S_STORE;
                S_STORE: state_reg <= S_FIN;
                S_ARD: state_reg <= st.limit_hit ? S_FIN : S_AWAIT;
                S_AWAIT: state_reg <= S_ACHK;
                S_ACHK: state_reg <= (st.slot_valid && !st.slot_room) ? S_ARD : S_FIN;
                S_QRD: state_reg <= (sidx_reg < stored) ? S_QWAIT : S_FIN;
                S_QWAIT: state_reg <= S_QCMP;
                S_QCMP: begin
                    sidx_reg <= sidx_reg + 1'b1;
                    state_reg <= S_QRD;
                end
                S_FIN: state_reg <= S_OUT;
                S_OUT: begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
    logic unused_f;
    assign unused_f = ^func_reg ^ st.admitted ^ st.hit;
endmodule

### rtl/pra_checker.sv
// Port-level checker for the page region allocator, bound to the top level.
`include "page_region_admit_allocator_assert.svh"
module pra_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [1:0]   m_tuser,
    input logic [327:0] m_tdata
);
    `PRA_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PRA_ASSERT_IMPLIES(a_one, aclk, aresetn, s_tready, !m_tvalid)
    `PRA_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready && !m_tvalid)
    `PRA_ASSERT_IMPLIES(a_page, aclk, aresetn, m_tvalid && m_tdata[63:0] != 64'd0, m_tuser[0])
endmodule

bind page_region_admit_allocator pra_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata));
